// File: hdl/eoc_pkg.sv
// Package for the encoder offset calibration block.
// Holds the widths, reset constants and controller/datapath interface types.
// No dependencies.
`timescale 1ns / 1ps

package eoc_pkg;

  localparam int COUNT_BITS = 13;
  localparam int ENC_N      = 1 << COUNT_BITS;
  localparam int HALF_N     = ENC_N / 2;
  localparam int OFFSET_W   = COUNT_BITS + 1;
  localparam int STEP_W     = 12;
  localparam int SCOUNT_W   = 13;
  localparam int STEPS_MAX  = 4096;
  localparam int OFF_W      = 28;
  localparam int SUM_W      = 30;
  localparam int DIV_W      = 30;
  localparam int DVS_W      = 14;
  localparam int DIV_CNT_W  = 5;

  localparam logic signed [OFF_W-1:0] MIN_RESET = OFF_W'(ENC_N - 1);
  localparam logic signed [OFF_W-1:0] MAX_RESET = -OFF_W'(ENC_N);

  typedef struct packed {
    logic load;
    logic apply;
    logic mean_start;
    logic emit;
  } eoc_cmd_t;

  typedef struct packed {
    logic div_done;
    logic last;
  } eoc_status_t;

endpackage

// File: hdl/eoc_divider.sv
// Iterative restoring divider, one quotient bit per clock cycle.
// Unsigned dividend and divisor; depends on eoc_pkg for the widths.
`timescale 1ns / 1ps

module eoc_divider (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [eoc_pkg::DIV_W-1:0]   dividend,
  input  logic [eoc_pkg::DVS_W-1:0]   divisor,
  output logic [eoc_pkg::DIV_W-1:0]   quotient,
  output logic                        done
);

  logic [eoc_pkg::DVS_W-1:0]     rem;
  logic [eoc_pkg::DIV_W-1:0]     quo;
  logic [eoc_pkg::DVS_W-1:0]     dvs;
  logic [eoc_pkg::DIV_CNT_W-1:0] cnt;
  logic                          running;
  logic [eoc_pkg::DVS_W:0]       trial;
  logic [eoc_pkg::DVS_W+1:0]     diff;

  assign trial    = {rem, quo[eoc_pkg::DIV_W-1]};
  assign diff     = {1'b0, trial} - {2'b00, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= !start && running &&
              (cnt == eoc_pkg::DIV_CNT_W'(eoc_pkg::DIV_W - 1));
      if (start) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + 1'b1;
        if (cnt == eoc_pkg::DIV_CNT_W'(eoc_pkg::DIV_W - 1)) begin
          running <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (running) begin
      if (!diff[eoc_pkg::DVS_W+1]) begin
        rem <= diff[eoc_pkg::DVS_W-1:0];
        quo <= {quo[eoc_pkg::DIV_W-2:0], 1'b1};
      end else begin
        rem <= trial[eoc_pkg::DVS_W-1:0];
        quo <= {quo[eoc_pkg::DIV_W-2:0], 1'b0};
      end
    end
  end

endmodule

// File: hdl/eoc_datapath.sv
// Datapath: step count register, run statistics, offset wrap and result registers.
// Depends on eoc_pkg and eoc_divider.
`timescale 1ns / 1ps

module eoc_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  eoc_pkg::eoc_cmd_t                   cmd,
  output eoc_pkg::eoc_status_t                status,
  input  logic                                cfg_write,
  input  logic [eoc_pkg::SCOUNT_W-1:0]        cfg_data,
  input  logic [eoc_pkg::COUNT_BITS-1:0]      raw_position,
  output logic                                done,
  output logic signed [eoc_pkg::OFFSET_W-1:0] step_offset,
  output logic                                is_last,
  output logic signed [eoc_pkg::OFFSET_W-1:0] min_offset,
  output logic signed [eoc_pkg::OFFSET_W-1:0] max_offset,
  output logic signed [eoc_pkg::OFFSET_W-1:0] mean_offset,
  output logic [eoc_pkg::COUNT_BITS-1:0]      stored_offset
);

  logic [eoc_pkg::SCOUNT_W-1:0]          step_count;
  logic [eoc_pkg::SCOUNT_W-1:0]          eff_steps;
  logic [eoc_pkg::SCOUNT_W-1:0]          steps;
  logic [eoc_pkg::STEP_W-1:0]            step_index;
  logic [eoc_pkg::COUNT_BITS-1:0]        raw;
  logic signed [eoc_pkg::OFF_W-1:0]      running_min;
  logic signed [eoc_pkg::OFF_W-1:0]      running_max;
  logic signed [eoc_pkg::SUM_W-1:0]      running_sum;
  logic signed [eoc_pkg::OFF_W-1:0]      off;
  logic signed [eoc_pkg::OFF_W-1:0]      off_raw;
  logic signed [eoc_pkg::OFF_W-1:0]      off_wrap;
  logic signed [eoc_pkg::SUM_W-1:0]      sum_next;
  logic                                  last;
  logic                                  sum_neg;
  logic                                  div_start;
  logic [eoc_pkg::DIV_W-1:0]             div_dividend;
  logic [eoc_pkg::DVS_W-1:0]             div_divisor;
  logic [eoc_pkg::DIV_W-1:0]             quotient;
  logic                                  div_done;
  logic [eoc_pkg::DIV_W-1:0]             mean_full;

  function automatic logic [eoc_pkg::DIV_W-1:0] DIV_W_neg(
    input logic signed [eoc_pkg::SUM_W-1:0] v
  );
    DIV_W_neg = eoc_pkg::DIV_W'(-v);
  endfunction

  always_comb begin
    if (step_count == '0) begin
      eff_steps = eoc_pkg::SCOUNT_W'(1);
    end else if (step_count > eoc_pkg::SCOUNT_W'(eoc_pkg::STEPS_MAX)) begin
      eff_steps = eoc_pkg::SCOUNT_W'(eoc_pkg::STEPS_MAX);
    end else begin
      eff_steps = step_count;
    end
  end

  always_comb begin
    div_start = cmd.load | cmd.mean_start;
    if (cmd.load) begin
      div_dividend = (eoc_pkg::DIV_W'(step_index) << (eoc_pkg::COUNT_BITS + 1))
                     + eoc_pkg::DIV_W'(eff_steps);
      div_divisor  = {eff_steps, 1'b0};
    end else begin
      div_dividend = running_sum[eoc_pkg::SUM_W-1] ? DIV_W_neg(running_sum)
                                                    : eoc_pkg::DIV_W'(running_sum);
      div_divisor  = {1'b0, steps};
    end
  end

  eoc_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (quotient),
    .done     (div_done)
  );

  always_comb begin
    off_raw = $signed(eoc_pkg::OFF_W'(raw))
              - $signed({1'b0, quotient[eoc_pkg::OFF_W-2:0]});
    if (off_raw > eoc_pkg::OFF_W'(eoc_pkg::HALF_N)) begin
      off_wrap = off_raw - eoc_pkg::OFF_W'(eoc_pkg::ENC_N);
    end else if (off_raw < -eoc_pkg::OFF_W'(eoc_pkg::HALF_N)) begin
      off_wrap = off_raw + eoc_pkg::OFF_W'(eoc_pkg::ENC_N);
    end else begin
      off_wrap = off_raw;
    end
    sum_next  = running_sum + {{(eoc_pkg::SUM_W - eoc_pkg::OFF_W){off_wrap[eoc_pkg::OFF_W-1]}},
                               off_wrap};
    mean_full = sum_neg ? (~quotient + 1'b1) : quotient;
  end

  assign status.div_done = div_done;
  assign status.last     = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_count  <= eoc_pkg::SCOUNT_W'(64);
      step_index  <= '0;
      running_min <= eoc_pkg::MIN_RESET;
      running_max <= eoc_pkg::MAX_RESET;
      running_sum <= '0;
      done        <= 1'b0;
    end else begin
      done <= cmd.emit;
      if (cfg_write) begin
        step_count <= cfg_data;
      end
      if (cmd.apply) begin
        if (off_wrap < running_min) begin
          running_min <= off_wrap;
        end
        if (off_wrap > running_max) begin
          running_max <= off_wrap;
        end
        running_sum <= sum_next;
      end
      if (cmd.emit) begin
        if (last) begin
          step_index  <= '0;
          running_min <= eoc_pkg::MIN_RESET;
          running_max <= eoc_pkg::MAX_RESET;
          running_sum <= '0;
        end else begin
          step_index <= step_index + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      raw   <= raw_position;
      steps <= eff_steps;
    end
    if (cmd.apply) begin
      off  <= off_wrap;
      last <= ({1'b0, step_index} + 1'b1) >= steps;
    end
    if (cmd.mean_start) begin
      sum_neg <= running_sum[eoc_pkg::SUM_W-1];
    end
    if (cmd.emit) begin
      step_offset <= off[eoc_pkg::OFFSET_W-1:0];
      is_last     <= last;
      if (last) begin
        min_offset    <= running_min[eoc_pkg::OFFSET_W-1:0];
        max_offset    <= running_max[eoc_pkg::OFFSET_W-1:0];
        mean_offset   <= mean_full[eoc_pkg::OFFSET_W-1:0];
        stored_offset <= mean_full[eoc_pkg::COUNT_BITS-1:0];
      end else begin
        min_offset    <= '0;
        max_offset    <= '0;
        mean_offset   <= '0;
        stored_offset <= '0;
      end
    end
  end

endmodule

// File: hdl/eoc_controller.sv
// Controller state machine sequencing the expected-count division, the
// statistics update, the mean division and the result transaction. Depends on eoc_pkg.
`timescale 1ns / 1ps

module eoc_controller (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  output eoc_pkg::eoc_cmd_t    cmd,
  input  eoc_pkg::eoc_status_t status
);

  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_DIV_EXP  = 5'b00010,
    S_CALC     = 5'b00100,
    S_DIV_MEAN = 5'b01000,
    S_EMIT     = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next     = state;
    cmd            = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_DIV_EXP;
        end
      end
      S_DIV_EXP: begin
        if (status.div_done) begin
          cmd.apply  = 1'b1;
          state_next = S_CALC;
        end
      end
      S_CALC: begin
        if (status.last) begin
          cmd.mean_start = 1'b1;
          state_next     = S_DIV_MEAN;
        end else begin
          state_next = S_EMIT;
        end
      end
      S_DIV_MEAN: begin
        if (status.div_done) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        cmd.emit   = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: hdl/encoder_offset_calibration_core.sv
// Encoder offset calibration, top level.
// Joins the controller and the datapath; depends on eoc_pkg and the modules below.
//
// Use: write step_count through cfg_write/cfg_data while the block is idle
// (reset value 64). For each calibration step present raw_position and raise
// start; the input transaction is taken at a clock edge with start high and
// busy low. Each reading yields one result transaction: done is high for
// exactly one cycle with step_offset, is_last and the summary fields, which
// are zero unless is_last is set. On the final step of a run the summary
// carries min, max, mean and stored offset, and the run state clears itself.
// Each step runs through the 30-bit divider, one quotient bit per cycle, which
// first forms the expected count and, on the last step, the mean. Busy falls
// in the cycle in which done is high, so the next transaction can be taken at
// the edge that takes the result; no new reading is taken before then.
// Synchronous reset returns the block to idle, clears the run and restores
// step_count to 64. The receiver cannot stall: results are not held beyond
// their strobe cycle.
`timescale 1ns / 1ps

module encoder_offset_calibration_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [eoc_pkg::COUNT_BITS-1:0]      raw_position,
  input  logic                                cfg_write,
  input  logic [eoc_pkg::SCOUNT_W-1:0]        cfg_data,
  output logic                                done,
  output logic signed [eoc_pkg::OFFSET_W-1:0] step_offset,
  output logic                                is_last,
  output logic signed [eoc_pkg::OFFSET_W-1:0] min_offset,
  output logic signed [eoc_pkg::OFFSET_W-1:0] max_offset,
  output logic signed [eoc_pkg::OFFSET_W-1:0] mean_offset,
  output logic [eoc_pkg::COUNT_BITS-1:0]      stored_offset
);

  eoc_pkg::eoc_cmd_t    cmd;
  eoc_pkg::eoc_status_t status;

  eoc_controller u_controller (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .status (status)
  );

  eoc_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .cfg_write     (cfg_write),
    .cfg_data      (cfg_data),
    .raw_position  (raw_position),
    .done          (done),
    .step_offset   (step_offset),
    .is_last       (is_last),
    .min_offset    (min_offset),
    .max_offset    (max_offset),
    .mean_offset   (mean_offset),
    .stored_offset (stored_offset)
  );

endmodule

// File: tb/testbench.sv
// Testbench for the encoder offset calibration core: directed and random runs of readings.
// Predicts each step offset and the end-of-run summary and compares every result.
// Depends on eoc_pkg and encoder_offset_calibration_core.
`timescale 1ns / 1ps

module testbench;

  typedef struct {
    int step_offset;
    int is_last;
    int min_offset;
    int max_offset;
    int mean_offset;
    int stored_offset;
  } offset_result_t;

  logic                                clk = 1'b0;
  logic                                rst = 1'b1;
  logic                                start = 1'b0;
  logic                                busy;
  logic [eoc_pkg::COUNT_BITS-1:0]      raw_position = '0;
  logic                                cfg_write = 1'b0;
  logic [eoc_pkg::SCOUNT_W-1:0]        cfg_data = '0;
  logic                                done;
  logic signed [eoc_pkg::OFFSET_W-1:0] step_offset;
  logic                                is_last;
  logic signed [eoc_pkg::OFFSET_W-1:0] min_offset;
  logic signed [eoc_pkg::OFFSET_W-1:0] max_offset;
  logic signed [eoc_pkg::OFFSET_W-1:0] mean_offset;
  logic [eoc_pkg::COUNT_BITS-1:0]      stored_offset;

  offset_result_t expected_results[$];
  int mismatch_count = 0;
  int readings_sent = 0;
  bit idle_on = 1'b1;

  logic [eoc_pkg::SCOUNT_W-1:0] cal_step_count = eoc_pkg::SCOUNT_W'(64);
  logic [eoc_pkg::STEP_W-1:0]   cal_step_index = '0;
  int cal_min = eoc_pkg::ENC_N - 1;
  int cal_max = -eoc_pkg::ENC_N;
  int cal_sum = 0;

  encoder_offset_calibration_core uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .raw_position(raw_position),
    .cfg_write(cfg_write),
    .cfg_data(cfg_data),
    .done(done),
    .step_offset(step_offset),
    .is_last(is_last),
    .min_offset(min_offset),
    .max_offset(max_offset),
    .mean_offset(mean_offset),
    .stored_offset(stored_offset)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int active_steps();
    if (cal_step_count == 0) return 1;
    if (cal_step_count > eoc_pkg::STEPS_MAX) return eoc_pkg::STEPS_MAX;
    return int'(cal_step_count);
  endfunction

  function automatic int commanded_count();
    longint steps;
    longint num;
    steps = active_steps();
    num = 2 * longint'(cal_step_index) * eoc_pkg::ENC_N + steps;
    return int'(num / (2 * steps));
  endfunction

  function automatic int offset_field(input int v);
    logic signed [eoc_pkg::OFFSET_W-1:0] t;
    t = eoc_pkg::OFFSET_W'(v);
    return int'(t);
  endfunction

  task automatic predict_reading(input logic [eoc_pkg::COUNT_BITS-1:0] reading);
    offset_result_t r;
    int steps;
    int off;
    int mean;
    steps = active_steps();
    off = int'(reading) - commanded_count();
    if (off > eoc_pkg::HALF_N) off -= eoc_pkg::ENC_N;
    if (off < -eoc_pkg::HALF_N) off += eoc_pkg::ENC_N;
    if (off < cal_min) cal_min = off;
    if (off > cal_max) cal_max = off;
    cal_sum += off;
    r.step_offset = offset_field(off);
    r.is_last = 0;
    r.min_offset = 0;
    r.max_offset = 0;
    r.mean_offset = 0;
    r.stored_offset = 0;
    if (int'(cal_step_index) + 1 >= steps) begin
      mean = cal_sum / steps;
      r.is_last = 1;
      r.min_offset = offset_field(cal_min);
      r.max_offset = offset_field(cal_max);
      r.mean_offset = offset_field(mean);
      r.stored_offset = (mean + eoc_pkg::ENC_N) & (eoc_pkg::ENC_N - 1);
      cal_step_index = '0;
      cal_min = eoc_pkg::ENC_N - 1;
      cal_max = -eoc_pkg::ENC_N;
      cal_sum = 0;
    end else begin
      cal_step_index = cal_step_index + 1'b1;
    end
    expected_results.push_back(r);
  endtask

  task automatic report_mismatch(input string msg);
    if (mismatch_count < 100) $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  always @(posedge clk) begin : check_results
    offset_result_t want;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with no transaction pending");
      end else begin
        want = expected_results.pop_front();
        check_field("step_offset", int'(step_offset), want.step_offset);
        check_field("is_last", int'(is_last), want.is_last);
        check_field("min_offset", int'(min_offset), want.min_offset);
        check_field("max_offset", int'(max_offset), want.max_offset);
        check_field("mean_offset", int'(mean_offset), want.mean_offset);
        check_field("stored_offset", int'(stored_offset), want.stored_offset);
      end
    end
  end

  task automatic send_reading(input logic [eoc_pkg::COUNT_BITS-1:0] reading);
    if (idle_on && $urandom_range(99) < 15) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 70)) @(posedge clk);
    end
    start <= 1'b1;
    raw_position <= reading;
    do @(posedge clk); while (busy);
    predict_reading(reading);
    readings_sent++;
  endtask

  task automatic wait_for_results();
    start <= 1'b0;
    while (expected_results.size() != 0 || busy) @(posedge clk);
  endtask

  task automatic write_step_count(input logic [eoc_pkg::SCOUNT_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    cal_step_count = value;
  endtask

  function automatic logic [eoc_pkg::COUNT_BITS-1:0] random_reading();
    int unsigned mode;
    mode = $urandom_range(99);
    if (mode < 60) begin
      return eoc_pkg::COUNT_BITS'(commanded_count() + int'($urandom_range(200)) - 100);
    end
    if (mode < 75) begin
      return eoc_pkg::COUNT_BITS'(commanded_count() + eoc_pkg::HALF_N
                                  + int'($urandom_range(6)) - 3);
    end
    return eoc_pkg::COUNT_BITS'($urandom_range(eoc_pkg::ENC_N - 1));
  endfunction

  // The run begun under the reset step count is cut short by a smaller count.
  task automatic test_default_step_count();
    repeat (4) send_reading(random_reading());
    wait_for_results();
    write_step_count(eoc_pkg::SCOUNT_W'(2));
    send_reading(random_reading());
  endtask

  // Readings that land on and just beyond both ends of the offset range.
  task automatic test_offset_wrap();
    wait_for_results();
    write_step_count(eoc_pkg::SCOUNT_W'(8));
    send_reading(13'd4096);
    send_reading(13'd5121);
    send_reading(13'd8191);
    send_reading(13'd3072);
    send_reading(13'd0);
    send_reading(13'd1023);
    send_reading(13'd2048);
    send_reading(13'd8191);
  endtask

  task automatic test_step_count_limits();
    wait_for_results();
    write_step_count(eoc_pkg::SCOUNT_W'(0));
    send_reading(13'd4096);
    send_reading(13'd8191);
    wait_for_results();
    write_step_count(eoc_pkg::SCOUNT_W'(1));
    send_reading(13'd1);
    wait_for_results();
    write_step_count(eoc_pkg::SCOUNT_W'(8191));
    repeat (3) send_reading(random_reading());
    wait_for_results();
    write_step_count(eoc_pkg::SCOUNT_W'(eoc_pkg::STEPS_MAX));
    send_reading(random_reading());
    wait_for_results();
    write_step_count(eoc_pkg::SCOUNT_W'(1));
    send_reading(random_reading());
  endtask

  task automatic test_random_runs();
    int unsigned pick;
    int unsigned setting;
    int span;
    int count;
    int sent;
    sent = 0;
    while (sent < 1430) begin
      pick = $urandom_range(99);
      if (pick < 5) begin
        case ($urandom_range(3))
          0: setting = 0;
          1: setting = eoc_pkg::STEPS_MAX;
          2: setting = eoc_pkg::STEPS_MAX - 1;
          default: setting = 8191;
        endcase
      end else if (pick < 75) begin
        setting = $urandom_range(1, 16);
      end else if (pick < 95) begin
        setting = $urandom_range(17, 64);
      end else begin
        setting = $urandom_range(65, 300);
      end
      wait_for_results();
      write_step_count(eoc_pkg::SCOUNT_W'(setting));
      span = active_steps() - int'(cal_step_index);
      if (span < 1) span = 1;
      if (pick < 5 && span > 12) count = $urandom_range(1, 12);
      else if ($urandom_range(99) < 85) count = span;
      else count = $urandom_range(1, span);
      repeat (count) begin
        idle_on = (sent < 500 || sent >= 800);
        send_reading(random_reading());
        sent++;
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_default_step_count();
    test_offset_wrap();
    test_step_count_limits();
    test_random_runs();
    wait_for_results();
    repeat (70) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
